FILE: design/sicm_pkg.sv
// Shared constants and types for the spiral index colormap.
// No dependencies; used by the interfaces, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none
package sicm_pkg;
  localparam int unsigned NORM_BITS  = 16;        // width of the Q0.16 quotient
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_CLASS_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ORBIT_COUNT = 2'd1;

  localparam logic [15:0] TOTAL_RESET = 16'd1;
  localparam logic [15:0] ORBIT_RESET = 16'd4096;

  localparam logic [16:0] ONE_Q16         = 17'd65536;
  localparam logic [15:0] NINE_TENTHS_Q16 = 16'd58982;
  localparam logic [16:0] ONE_TENTH_Q16   = 17'd6554;
  localparam logic [17:0] THREE_Q16       = 18'd196608;
  localparam logic [32:0] HALF_Q16        = 33'd32768;

  // hue offsets for red, green, blue
  localparam logic [15:0] CH_OFFSET [3] = '{16'd0, 16'd43691, 16'd21845};

  typedef struct packed {
    logic vld;
    logic clamped;
  } sicm_tag_t;
endpackage
`default_nettype wire

FILE: design/sicm_if.sv
// Valid/ready channel interfaces: index words, color words, register writes.
// Depends on sicm_pkg for the register port widths.
`timescale 1ns / 1ps
`default_nettype none
interface sicm_idx_if #(parameter int INDEX_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] color_index;
  modport source (output valid, output color_index, input ready);
  modport sink   (input valid, input color_index, output ready);
endinterface

interface sicm_rgb_if #(parameter int COLOR_FRAC_BITS = 12);
  logic                     valid;
  logic                     ready;
  logic [COLOR_FRAC_BITS:0] red;
  logic [COLOR_FRAC_BITS:0] green;
  logic [COLOR_FRAC_BITS:0] blue;
  logic                     index_clamped;
  modport source (output valid, output red, output green, output blue,
                  output index_clamped, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input index_clamped, output ready);
endinterface

interface sicm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sicm_pkg::CFG_ADDR_W-1:0]  index;
  logic [sicm_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/spiral_index_colormap_top.sv
// Spiral index colormap: index -> normalized n -> HSV -> RGB, fully pipelined.
// Stages: 1 input stage, 16 divider stages and 5 color stages lie between index accept
// and color word valid. Throughput: one word per cycle while the output is not stalled; the
// 16-stage restoring divider sets the depth. A stall at the output holds every stage.
// Reset: synchronous, active high; clears stage valids and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module spiral_index_colormap_top #(
  parameter int INDEX_BITS      = 16,
  parameter int COLOR_FRAC_BITS = 12
) (
  input wire logic clk,
  input wire logic rst,
  sicm_idx_if.sink   idx,
  sicm_rgb_if.source rgb,
  sicm_cfg_if.sink   cfg
);
  localparam int unsigned NB  = sicm_pkg::NORM_BITS;
  localparam int unsigned CMP = (INDEX_BITS > 16) ? INDEX_BITS : 16;
  localparam int unsigned CW  = COLOR_FRAC_BITS + 1;
  localparam int unsigned SH  = 48 - COLOR_FRAC_BITS;
  localparam logic [49:0] RND = 50'd1 << (SH - 1);
  localparam logic [CW-1:0] COLOR_ONE = CW'(1) << COLOR_FRAC_BITS;

  logic [15:0] class_count;
  logic [15:0] orbit_count;
  logic        en;

  // register writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= sicm_pkg::TOTAL_RESET;
      orbit_count <= sicm_pkg::ORBIT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == sicm_pkg::REG_CLASS_COUNT) class_count <= cfg.data;
      if (cfg.index == sicm_pkg::REG_ORBIT_COUNT) orbit_count <= cfg.data;
    end
  end

  // whole pipe advances unless the output word is held
  assign en        = !rgb.valid || rgb.ready;
  assign idx.ready = en;

  // input stage: range check
  sicm_pkg::sicm_tag_t s0_tag;
  logic [NB-1:0]       s0_rem;
  logic                in_clamp;
  assign in_clamp = CMP'(idx.color_index) >= CMP'(class_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_tag <= '0;
    end else if (en) begin
      s0_tag <= '{vld: idx.valid, clamped: in_clamp};
    end
    if (en) s0_rem <= in_clamp ? '0 : NB'(idx.color_index);
  end

  sicm_pkg::sicm_tag_t dv_tag;
  logic [NB-1:0]       dv_quo;

  sicm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (s0_tag),
    .rem_in  (s0_rem),
    .divisor (class_count),
    .tag_out (dv_tag),
    .quo_out (dv_quo)
  );

  logic [16:0] n;
  assign n = dv_tag.clamped ? sicm_pkg::ONE_Q16 : {1'b0, dv_quo};

  // stage A: hue and 0.9n
  sicm_pkg::sicm_tag_t a_tag;
  logic [15:0]         a_hue;
  logic [15:0]         a_t;
  logic [32:0]         hue_prod;
  logic [32:0]         t_prod;
  assign hue_prod = n * orbit_count;
  assign t_prod   = n * sicm_pkg::NINE_TENTHS_Q16 + sicm_pkg::HALF_Q16;

  // stage B: s, v, per channel hue ramp
  sicm_pkg::sicm_tag_t b_tag;
  logic [16:0]         b_s;
  logic [16:0]         b_v;
  logic [16:0]         b_q [3];
  logic [16:0]         q_c [3];

  always_comb begin
    logic [15:0] f;
    logic [18:0] f6;
    logic [17:0] p;
    for (int c = 0; c < 3; c++) begin
      f  = a_hue + sicm_pkg::CH_OFFSET[c];
      f6 = 19'(f) * 19'd6;
      p  = (f6 >= 19'(sicm_pkg::THREE_Q16)) ? 18'(f6 - 19'(sicm_pkg::THREE_Q16))
                                            : 18'(19'(sicm_pkg::THREE_Q16) - f6);
      if (p <= 18'(sicm_pkg::ONE_Q16))       q_c[c] = '0;
      else if (p >= 18'(2 * 65536))          q_c[c] = sicm_pkg::ONE_Q16;
      else                                   q_c[c] = 17'(p - 18'(sicm_pkg::ONE_Q16));
    end
  end

  // stage C: m = (1-s) + s*q in Q.32
  sicm_pkg::sicm_tag_t c_tag;
  logic [16:0]         c_v;
  logic [32:0]         c_m [3];

  // stage D: v*m split into two partial products
  sicm_pkg::sicm_tag_t d_tag;
  logic [32:0]         d_lo [3];
  logic [33:0]         d_hi [3];

  // stage E: output word
  logic [CW-1:0]       e_ch [3];
  logic                e_clamped;
  logic                e_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
      b_tag <= '0;
      c_tag <= '0;
      d_tag <= '0;
      e_vld <= 1'b0;
    end else if (en) begin
      a_tag <= dv_tag;
      b_tag <= a_tag;
      c_tag <= b_tag;
      d_tag <= c_tag;
      e_vld <= d_tag.vld;
    end
    if (en) begin
      a_hue <= hue_prod[27:12];
      a_t   <= t_prod[31:16];
      b_s   <= sicm_pkg::ONE_TENTH_Q16 + 17'(a_t);
      b_v   <= sicm_pkg::ONE_Q16 - 17'(a_t);
      c_v   <= b_v;
      e_clamped <= d_tag.clamped;
      for (int c = 0; c < 3; c++) begin
        b_q[c]  <= q_c[c];
        c_m[c]  <= {16'(sicm_pkg::ONE_Q16 - b_s), 16'd0} + 33'(b_s) * 33'(b_q[c]);
        d_lo[c] <= c_v * c_m[c][15:0];
        d_hi[c] <= c_v * c_m[c][32:16];
        e_ch[c] <= CW'(({d_hi[c], 16'd0} + 50'(d_lo[c]) + RND) >> SH);
      end
    end
  end

  assign rgb.valid         = e_vld;
  assign rgb.red           = e_ch[0];
  assign rgb.green         = e_ch[1];
  assign rgb.blue          = e_ch[2];
  assign rgb.index_clamped = e_clamped;

`ifndef SYNTHESIS
  a_range: assert property (@(posedge clk) disable iff (rst)
    rgb.valid |-> (rgb.red <= COLOR_ONE && rgb.green <= COLOR_ONE && rgb.blue <= COLOR_ONE))
    else $error("color word above full scale");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    (idx.valid && idx.ready && in_clamp) |=> (s0_tag.vld && s0_tag.clamped))
    else $error("out of range index not flagged at input stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(a_tag) && $stable(d_tag) && $stable(dv_tag)))
    else $error("pipeline moved during output stall");
`endif
endmodule
`default_nettype wire

FILE: design/sicm_div.sv
// Pipelined restoring divider: one quotient bit per stage, NORM_BITS stages.
// Computes floor(rem_in * 2^NORM_BITS / divisor) for rem_in < divisor. Uses sicm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sicm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire sicm_pkg::sicm_tag_t           tag_in,
  input  wire logic [sicm_pkg::NORM_BITS-1:0] rem_in,
  input  wire logic [sicm_pkg::NORM_BITS-1:0] divisor,
  output sicm_pkg::sicm_tag_t                tag_out,
  output logic [sicm_pkg::NORM_BITS-1:0]     quo_out
);
  localparam int unsigned NB = sicm_pkg::NORM_BITS;

  sicm_pkg::sicm_tag_t tag [NB+1];
  logic [NB-1:0]       rem [NB+1];
  logic [NB-1:0]       quo [NB+1];

  assign tag[0] = tag_in;
  assign rem[0] = rem_in;
  assign quo[0] = '0;

  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic [NB:0] shifted;
    logic        take;
    assign shifted = {rem[i], 1'b0};
    assign take    = shifted >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[i+1] <= '0;
      end else if (en) begin
        tag[i+1] <= tag[i];
      end
      if (en) begin
        rem[i+1] <= take ? NB'(shifted - {1'b0, divisor}) : shifted[NB-1:0];
        quo[i+1] <= {quo[i][NB-2:0], take};
      end
    end
  end

  assign tag_out = tag[NB];
  assign quo_out = quo[NB];
endmodule
`default_nettype wire

FILE: bench/tb_spiral_index_colormap_top.sv
// Self-checking bench for the spiral index colormap: predicts each color word
// from the index and the register settings, checks outputs in order.
// Depends on sicm_pkg, sicm_if and spiral_index_colormap_top.
`timescale 1ns / 1ps
module tb_spiral_index_colormap_top;
  localparam int CF = 12;

  typedef struct packed {
    logic [CF:0] red;
    logic [CF:0] green;
    logic [CF:0] blue;
    logic        clamped;
  } color_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  sicm_idx_if #(.INDEX_BITS(16)) idx ();
  sicm_rgb_if #(.COLOR_FRAC_BITS(CF)) rgb ();
  sicm_cfg_if cfg ();

  spiral_index_colormap_top i_dut (.clk(clk), .rst(rst), .idx(idx), .rgb(rgb), .cfg(cfg));

  color_word_t expected_colors[$];
  logic [15:0] class_count_q;
  logic [15:0] orbit_q;
  int          err_count = 0;
  int          words_seen = 0;
  int          cycle_count = 0;
  int          idle_pct = 34;

  initial begin
    idx.valid = 1'b0;
    idx.color_index = '0;
    rgb.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch word %0d %s: got %0d want %0d", words_seen, what, got, want);
    err_count++;
  endtask

  function automatic logic [CF:0] channel_level(logic [15:0] hue, logic [15:0] offset,
                                                logic [63:0] s, logic [63:0] v);
    logic [63:0] f, f6, p, q, m, r;
    f = 64'((hue + offset) & 16'hFFFF);
    f6 = f * 6;
    p = (f6 >= 64'd196608) ? f6 - 64'd196608 : 64'd196608 - f6;
    q = (p > 64'd65536) ? p - 64'd65536 : 64'd0;
    if (q > 64'd65536) q = 64'd65536;
    m = (64'd65536 - s) * 64'd65536 + s * q;
    r = (v * m + (64'd1 << (47 - CF))) >> (48 - CF);
    return r[CF:0];
  endfunction

  function automatic color_word_t predict_color(logic [15:0] ci);
    color_word_t w;
    logic [63:0] n, hue, t, s, v;
    if (class_count_q == 0 || ci >= class_count_q) begin
      n = 64'd65536;
      w.clamped = 1'b1;
    end else begin
      n = (64'(ci) << 16) / 64'(class_count_q);
      w.clamped = 1'b0;
    end
    hue = ((n * 64'(orbit_q)) & ((64'd1 << 28) - 1)) >> 12;
    t = (64'd58982 * n + 64'd32768) >> 16;
    s = 64'd6554 + t;
    v = 64'd65536 - t;
    w.red = channel_level(hue[15:0], sicm_pkg::CH_OFFSET[0], s, v);
    w.green = channel_level(hue[15:0], sicm_pkg::CH_OFFSET[1], s, v);
    w.blue = channel_level(hue[15:0], sicm_pkg::CH_OFFSET[2], s, v);
    return w;
  endfunction

  // result side: random stall, check in order
  always @(posedge clk) begin
    color_word_t w;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (rgb.valid && rgb.ready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          w = expected_colors.pop_front();
          if (rgb.red !== w.red) report_mismatch("red", rgb.red, w.red);
          if (rgb.green !== w.green) report_mismatch("green", rgb.green, w.green);
          if (rgb.blue !== w.blue) report_mismatch("blue", rgb.blue, w.blue);
          if (rgb.index_clamped !== w.clamped)
            report_mismatch("clamped", rgb.index_clamped, w.clamped);
        end
        words_seen++;
      end
      rgb.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_spiral_index_colormap_top: errors");
      $finish;
    end
  end

  task automatic send_index(input logic [15:0] ci);
    if ($urandom_range(99) < idle_pct) begin
      idx.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    idx.valid <= 1'b1;
    idx.color_index <= ci;
    do @(posedge clk); while (!idx.ready);
    expected_colors.insert(expected_colors.size(), predict_color(ci));
  endtask

  task automatic drain_pipe();
    idx.valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sicm_pkg::CFG_ADDR_W-1:0] r, input logic [15:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= r;
    cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (r == sicm_pkg::REG_CLASS_COUNT) class_count_q = d;
    else if (r == sicm_pkg::REG_ORBIT_COUNT) orbit_q = d;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] tot, input logic [15:0] orb);
    drain_pipe();
    write_reg(sicm_pkg::REG_CLASS_COUNT, tot);
    write_reg(sicm_pkg::REG_ORBIT_COUNT, orb);
  endtask

  task automatic test_reset_defaults();
    send_index(16'd0);
    send_index(16'd1);
    send_index(16'hFFFF);
  endtask

  task automatic test_directed_edges();
    set_regs(16'd7, 16'd12067);
    for (int i = 0; i <= 7; i++) send_index(16'(i));
    send_index(16'hFFFF);
    set_regs(16'hFFFF, 16'hFFFF);
    send_index(16'd0);
    send_index(16'hFFFE);
    send_index(16'hFFFF);
    send_index(16'h5555);
    send_index(16'hAAAA);
    set_regs(16'd0, 16'd0);  // zero total clamps every index
    send_index(16'd0);
    send_index(16'h1234);
    set_regs(16'd3, 16'd100);  // orbit below one
    send_index(16'd1);
    send_index(16'd2);
  endtask

  task automatic test_random_settings();
    logic [15:0] tot;
    for (int ph = 0; ph < 8; ph++) begin
      tot = (ph % 2) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 300));
      set_regs(tot, 16'($urandom_range(0, 65535)));
      idle_pct = (ph == 3) ? 0 : 34;  // one stretch with no idling
      for (int k = 0; k < 78; k++) begin
        if ($urandom_range(9) == 0) send_index(16'($urandom));
        else send_index(16'($urandom_range(0, tot)));
      end
    end
    idle_pct = 34;
  endtask

  initial begin
    class_count_q = sicm_pkg::TOTAL_RESET;
    orbit_q = sicm_pkg::ORBIT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_edges();
    test_random_settings();
    drain_pipe();
    $display("covered %0d color words over reset, edge, zero-total and random settings",
             words_seen);
    if (err_count == 0) begin
      $display("tb_spiral_index_colormap_top: clean");
    end else begin
      $display("tb_spiral_index_colormap_top: errors");
    end
    $finish;
  end
endmodule
